// ===== hdl/nqsc_pkg.sv =====
package nqsc_pkg;

    // Result field widths and limits
    localparam int unsigned COUNT_W   = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFF_FFFF;
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned FIRST_W   = 4;
    localparam logic [CFG_W-1:0] BOARD_RESET = 5'd8;

    // Microprogram address
    localparam int unsigned UPC_W = 3;
    typedef logic [UPC_W-1:0] t_upc;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_SEED,
        OP_PLACE,
        OP_POP,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_IN,
        C_STOP,
        C_NO_CAND,
        C_ROW_ONE,
        C_OUT_BUSY
    } t_cond;

    // One control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  in_rdy;
        t_upc  target;
    } t_ucode;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic no_cand;
        logic row_one;
        logic stop;
        logic out_busy;
    } t_status;

    // Program steps
    localparam t_upc S_IDLE   = 3'd0;
    localparam t_upc S_CHECK  = 3'd1;
    localparam t_upc S_TRY    = 3'd2;
    localparam t_upc S_PLACE  = 3'd3;
    localparam t_upc S_BACK   = 3'd4;
    localparam t_upc S_POP    = 3'd5;
    localparam t_upc S_SPARE  = 3'd6;
    localparam t_upc S_FINISH = 3'd7;

    // Control store: jump to target when the condition holds, else fall through
    function automatic t_ucode ucode_rom(input t_upc addr);
        t_ucode w;
        w = '{op: OP_NOP, cond: C_ALWAYS, in_rdy: 1'b0, target: S_IDLE};
        unique case (addr)
            S_IDLE:   w = '{op: OP_SEED,  cond: C_NO_IN,    in_rdy: 1'b1, target: S_IDLE};
            S_CHECK:  w = '{op: OP_NOP,   cond: C_STOP,     in_rdy: 1'b0, target: S_FINISH};
            S_TRY:    w = '{op: OP_NOP,   cond: C_NO_CAND,  in_rdy: 1'b0, target: S_BACK};
            S_PLACE:  w = '{op: OP_PLACE, cond: C_ALWAYS,   in_rdy: 1'b0, target: S_TRY};
            S_BACK:   w = '{op: OP_NOP,   cond: C_ROW_ONE,  in_rdy: 1'b0, target: S_FINISH};
            S_POP:    w = '{op: OP_POP,   cond: C_ALWAYS,   in_rdy: 1'b0, target: S_TRY};
            S_SPARE:  w = '{op: OP_NOP,   cond: C_ALWAYS,   in_rdy: 1'b0, target: S_IDLE};
            S_FINISH: w = '{op: OP_EMIT,  cond: C_OUT_BUSY, in_rdy: 1'b0, target: S_FINISH};
            default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   in_rdy: 1'b0, target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/nqsc_sequencer.sv =====
module nqsc_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  nqsc_pkg::t_status i_status,
    output nqsc_pkg::t_ucode  o_ctrl
);
    import nqsc_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_ucode w_word;
    logic   w_take;

    // Fetch the control word for this step
    assign w_word = ucode_rom(r_upc);
    assign o_ctrl = w_word;

    // Select the jump condition
    always_comb begin
        unique case (w_word.cond)
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = !i_valid;
            C_STOP:     w_take = i_status.stop;
            C_NO_CAND:  w_take = i_status.no_cand;
            C_ROW_ONE:  w_take = i_status.row_one;
            C_OUT_BUSY: w_take = i_status.out_busy;
            default:    w_take = 1'b1;
        endcase
        n_upc = w_take ? w_word.target : r_upc + t_upc'(1);
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== hdl/nqsc_datapath.sv =====
module nqsc_datapath #(
    parameter int unsigned MAX_BOARD = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nqsc_pkg::t_ucode                i_ctrl,
    input  logic                            i_accept,
    input  logic [nqsc_pkg::FIRST_W-1:0]    i_first_column,
    input  logic [nqsc_pkg::CFG_W-1:0]      i_board_size,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [nqsc_pkg::COUNT_W-1:0]    o_solution_count,
    output logic                            o_bad_column,
    output nqsc_pkg::t_status               o_status
);
    import nqsc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_BOARD);
    localparam int unsigned NW = $clog2(MAX_BOARD + 1);
    localparam int unsigned DW = 2 * MAX_BOARD - 1;

    // Search state
    logic [MAX_BOARD-1:0] r_cols;
    logic [DW-1:0]        r_d1;
    logic [DW-1:0]        r_d2;
    logic [CW-1:0]        r_row;
    logic [CW:0]          r_start;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_bad;
    logic [CW-1:0]        r_stack [MAX_BOARD];

    // Output register
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_bad;

    logic [NW-1:0]        w_n;
    logic                 w_in_bad;
    logic [CW-1:0]        w_seed_col;
    logic [DW-1:0]        w_d1s;
    logic [DW-1:0]        w_d2s;
    logic [MAX_BOARD-1:0] w_cand;
    logic [CW-1:0]        w_pick;
    logic                 w_last;
    logic [CW-1:0]        w_pop_row;
    logic [CW-1:0]        w_pop_col;
    logic                 w_out_busy;

    // Clamp the board size to the array size
    assign w_n = (32'(i_board_size) > MAX_BOARD) ? NW'(MAX_BOARD) : NW'(i_board_size);
    assign w_in_bad   = 32'(i_first_column) >= 32'(w_n);
    assign w_seed_col = w_in_bad ? '0 : CW'(32'(i_first_column));

    // Free squares of the current row from the start column on
    assign w_d1s = r_d1 >> r_row;
    assign w_d2s = r_d2 >> r_row;
    always_comb begin
        for (int c = 0; c < MAX_BOARD; c++) begin
            w_cand[c] = (32'(c) < 32'(w_n)) && !r_cols[c] && !w_d1s[c]
                        && !w_d2s[MAX_BOARD-1-c] && ((CW+1)'(c) >= r_start);
        end
        w_pick = '0;
        for (int c = MAX_BOARD - 1; c >= 0; c--) begin
            if (w_cand[c]) begin
                w_pick = CW'(c);
            end
        end
    end

    assign w_last     = (32'(r_row) + 32'd1) == 32'(w_n);
    assign w_pop_row  = r_row - CW'(1);
    assign w_pop_col  = r_stack[w_pop_row];
    assign w_out_busy = r_out_valid && !i_ready;

    assign o_status.no_cand  = (w_cand == '0);
    assign o_status.row_one  = (r_row == CW'(1));
    assign o_status.stop     = r_bad || (w_n == NW'(1));
    assign o_status.out_busy = w_out_busy;

    // Search registers
    always_ff @(posedge i_clk) begin
        priority case (1'b1)
            (i_ctrl.op == OP_SEED) && i_accept: begin
                r_cols    <= MAX_BOARD'(1) << w_seed_col;
                r_d1      <= DW'(1) << w_seed_col;
                r_d2      <= DW'(1) << (32'(MAX_BOARD - 1) - 32'(w_seed_col));
                r_row     <= CW'(1);
                r_start   <= '0;
                r_bad     <= w_in_bad;
                r_count   <= (!w_in_bad && w_n == NW'(1)) ? COUNT_W'(1) : '0;
                r_stack[0] <= w_seed_col;
            end
            i_ctrl.op == OP_PLACE: begin
                r_stack[r_row] <= w_pick;
                if (w_last) begin
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                    r_start <= (CW+1)'(w_pick) + (CW+1)'(1);
                end else begin
                    r_cols  <= r_cols | (MAX_BOARD'(1) << w_pick);
                    r_d1    <= r_d1 | (DW'(1) << (32'(r_row) + 32'(w_pick)));
                    r_d2    <= r_d2 | (DW'(1) << (32'(r_row) + 32'(MAX_BOARD - 1)
                                                 - 32'(w_pick)));
                    r_row   <= r_row + CW'(1);
                    r_start <= '0;
                end
            end
            i_ctrl.op == OP_POP: begin
                // Lift the queen of the previous row and resume past it
                r_cols  <= r_cols & ~(MAX_BOARD'(1) << w_pop_col);
                r_d1    <= r_d1 & ~(DW'(1) << (32'(w_pop_row) + 32'(w_pop_col)));
                r_d2    <= r_d2 & ~(DW'(1) << (32'(w_pop_row) + 32'(MAX_BOARD - 1)
                                               - 32'(w_pop_col)));
                r_row   <= w_pop_row;
                r_start <= (CW+1)'(w_pop_col) + (CW+1)'(1);
            end
            default: begin
            end
        endcase
    end

    // Hold the result until the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == OP_EMIT && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_EMIT && !w_out_busy) begin
            r_out_count <= r_count;
            r_out_bad   <= r_bad;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_solution_count = r_out_count;
    assign o_bad_column     = r_out_bad;

endmodule

// ===== hdl/n_queens_solution_counter.sv =====
// N-queens solution counter.
// Input channel: i_valid / o_ready carry one beat, i_first_column, the column
// of the row-zero queen. Output channel: o_valid / i_ready carry one beat,
// o_solution_count (saturating at 2^24-1) and o_bad_column, set with a zero
// count when the column is not below the board size.
// Board size is written through i_cfg_we / i_cfg_data; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Sizes above MAX_BOARD are searched as MAX_BOARD. One item is searched at a
// time. A microcoded sequencer steps a backtracking datapath: a queen
// placement takes a try and a place step, a backtrack the failed try, the
// step back and the pop, and seeding and finishing add their own steps. A
// bad column or a one-square board goes from the idle step through the check
// step to the finishing step, which loads the output register. The size of
// the search tree sets how long a search runs. The result sits in an output
// register; o_ready rises again in the cycle after the result is loaded, so
// a new search runs while the last result waits. A finished search holds
// until that register is free. Reset (synchronous, active low) returns to
// idle, drops o_valid and o_ready and sets the board size to 8.
module n_queens_solution_counter #(
    parameter int unsigned MAX_BOARD = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nqsc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [nqsc_pkg::FIRST_W-1:0] i_first_column,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [nqsc_pkg::COUNT_W-1:0] o_solution_count,
    output logic                         o_bad_column
);
    import nqsc_pkg::*;

    logic [CFG_W-1:0] r_board_size;
    t_ucode           w_ctrl;
    t_status          w_status;
    logic             w_accept;

    // Board size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= BOARD_RESET;
        end else if (i_cfg_we) begin
            r_board_size <= i_cfg_data;
        end
    end

    // Take no beat while reset is held
    assign o_ready  = w_ctrl.in_rdy && i_rst_n;
    assign w_accept = i_valid && o_ready;

    nqsc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    nqsc_datapath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .i_accept         (w_accept),
        .i_first_column   (i_first_column),
        .i_board_size     (r_board_size),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_solution_count (o_solution_count),
        .o_bad_column     (o_bad_column),
        .o_status         (w_status)
    );

    // A bad column always reports a zero count
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_column |-> o_solution_count == '0)
        else $error("bad column with nonzero count");

    // No second beat is taken right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("input accepted during search");

    // A result appears only from the finishing step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_ctrl.op == OP_EMIT))
        else $error("result raised outside finish step");

endmodule
